@@ sv/erle_pkg.sv @@
// shared types for the escaped run-length decoder
package erle_pkg;

    localparam int unsigned ByteW = 8;

    // one decoded run or literal descriptor
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] value;
        logic [ByteW-1:0] count;
        logic             done;
    } t_result;

    // decoder state flags and counters
    typedef struct packed {
        logic             expect_header;
        logic             run_mode;
        logic             escape_pending;
        logic             have_count;
        logic [ByteW-1:0] pending_count;
        logic [ByteW-1:0] frame_length;
        logic [ByteW-1:0] produced;
    } t_state;

endpackage

@@ sv/erle_step.sv @@
// per-byte decode logic and decoder state registers
module erle_step
    import erle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [ByteW-1:0] i_byte,
    output t_result          o_res
);

    t_state r_st;
    t_state n_st;

    logic             run_eff;
    logic             hc_eff;
    logic             do_plain;
    logic             do_emit;
    logic [ByteW-1:0] emit_value;
    logic [ByteW-1:0] emit_count;
    logic [ByteW-1:0] remaining;
    logic [ByteW-1:0] clipped;
    logic             done;

    // mode, escape and count decisions for one byte
    always_comb begin
        n_st       = r_st;
        run_eff    = r_st.run_mode;
        hc_eff     = r_st.have_count;
        do_plain   = 1'b0;
        do_emit    = 1'b0;
        emit_value = '0;
        emit_count = '0;
        if (r_st.expect_header) begin
            if (i_byte != '0) begin
                n_st.frame_length   = i_byte;
                n_st.produced       = '0;
                n_st.expect_header  = 1'b0;
                n_st.run_mode       = 1'b1;
                n_st.escape_pending = 1'b0;
                n_st.have_count     = 1'b0;
                n_st.pending_count  = '0;
            end
        end else if (r_st.escape_pending) begin
            n_st.escape_pending = 1'b0;
            if (i_byte == '0) begin
                do_emit    = 1'b1;
                emit_value = '0;
                emit_count = ByteW'(1);
            end else begin
                run_eff         = ~r_st.run_mode;
                hc_eff          = 1'b0;
                n_st.run_mode   = run_eff;
                n_st.have_count = 1'b0;
                do_plain        = 1'b1;
            end
        end else if (i_byte == '0 && !(r_st.run_mode && r_st.have_count)) begin
            n_st.escape_pending = 1'b1;
        end else begin
            do_plain = 1'b1;
        end

        // byte handled in the current mode
        if (do_plain) begin
            if (!run_eff) begin
                do_emit    = 1'b1;
                emit_value = i_byte;
                emit_count = ByteW'(1);
            end else if (!hc_eff) begin
                n_st.pending_count = i_byte;
                n_st.have_count    = 1'b1;
            end else begin
                n_st.have_count = 1'b0;
                do_emit         = 1'b1;
                emit_value      = i_byte;
                emit_count      = r_st.pending_count;
            end
        end

        // clip at frame length, frame end resets decode state
        remaining = r_st.frame_length - r_st.produced;
        clipped   = (emit_count > remaining) ? remaining : emit_count;
        done      = (clipped == remaining);
        if (do_emit) begin
            n_st.produced = r_st.produced + clipped;
            if (done) begin
                n_st.expect_header  = 1'b1;
                n_st.run_mode       = 1'b1;
                n_st.escape_pending = 1'b0;
                n_st.have_count     = 1'b0;
                n_st.pending_count  = '0;
            end
        end

        o_res.valid = do_emit;
        o_res.value = emit_value;
        o_res.count = clipped;
        o_res.done  = done;
    end

    // state update on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.expect_header  <= 1'b1;
            r_st.run_mode       <= 1'b1;
            r_st.escape_pending <= 1'b0;
            r_st.have_count     <= 1'b0;
            r_st.pending_count  <= '0;
            r_st.frame_length   <= '0;
            r_st.produced       <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    // a descriptor never carries a zero count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.valid |-> o_res.count != '0)
        else $error("zero-count descriptor");

    // inside a frame the output count stays below the declared length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.expect_header |-> r_st.produced < r_st.frame_length)
        else $error("produced count overran frame length");

    // an escape is only pending inside a frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.escape_pending |-> !r_st.expect_header)
        else $error("escape pending while waiting for header");

    // frame completion returns to header wait in run mode
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.valid && o_res.done
        |=> r_st.expect_header && r_st.run_mode && !r_st.have_count)
        else $error("frame end did not reset decode state");

endmodule

@@ sv/escaped_rle_decoder_core.sv @@
// escaped run-length decoder top level: input register, decode step, result register
// A word is decoded from the input register; any descriptor it yields is registered.
// Throughput: one compressed byte per cycle, sustained while the result side takes words.
// The input register is refilled in the cycle its word is decoded; the result register
// keeps a finished descriptor while the next byte is taken in.
// Reset (synchronous, active low) empties both registers and sets header wait, run mode.
module escaped_rle_decoder_core
    import erle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ByteW-1:0] i_in_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ByteW-1:0] o_out_value,
    output logic [ByteW-1:0] o_out_count,
    output logic             o_frame_done
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_value;
    logic [ByteW-1:0] r_out_count;
    logic             r_out_done;
    logic             out_free;
    logic             fire;
    t_result          res;

    // decode the held word when the result register can take its output
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || fire;

    erle_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out_value <= res.value;
            r_out_count <= res.count;
            r_out_done  <= res.done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_count  = r_out_count;
    assign o_frame_done = r_out_done;

    // a word is decoded only when its result has room
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> (!r_out_valid || i_out_ready))
        else $error("decode while result register blocked");

    // a waiting result is held until it is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_count))
        else $error("pending result lost");

    // the held word is never overwritten before it is decoded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte))
        else $error("held input word overwritten");

endmodule
